[design/mngt_pkg.sv]
// Shared types, constants and level/glyph helpers for the MIDI note glyph tracker.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package mngt_pkg;

   // default geometry of the note cell store
   localparam int CHANNELS_DEF = 16;
   localparam int PITCHES_DEF  = 128;

   // MIDI message types (high nibble of status)
   localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
   localparam logic [3:0] TYPE_CONTROL  = 4'hB;

   // controller numbers
   localparam logic [6:0] CC_VOLUME = 7'd7;
   localparam logic [6:0] CC_PAN    = 7'd10;

   // reset value of volume and pan
   localparam logic [6:0] CC_RESET = 7'd64;

   // result action codes
   localparam logic [2:0] ACT_IGNORE = 3'd0;
   localparam logic [2:0] ACT_VOLUME = 3'd1;
   localparam logic [2:0] ACT_PAN    = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;
   localparam logic [2:0] ACT_DRAW   = 3'd4;
   localparam logic [2:0] ACT_READ   = 3'd5;

   // glyph codes
   localparam logic [7:0] GLYPH_LEFT  = 8'h4C;
   localparam logic [7:0] GLYPH_RIGHT = 8'h52;
   localparam logic [7:0] GLYPH_LIGHT = 8'hB0;
   localparam logic [7:0] GLYPH_MED   = 8'hB1;
   localparam logic [7:0] GLYPH_DARK  = 8'hB2;
   localparam logic [7:0] GLYPH_FULL  = 8'hDB;

   // pan limits
   localparam logic [6:0] PAN_LEFT_LIM  = 7'd52;
   localparam logic [6:0] PAN_RIGHT_LIM = 7'd76;
   localparam logic [6:0] PAN_MAX       = 7'd127;

   // foreground thresholds 5/43/84 scaled by 127, on p = velocity * volume
   localparam logic [13:0] FG_T1 = 14'd635;
   localparam logic [13:0] FG_T2 = 14'd5461;
   localparam logic [13:0] FG_T3 = 14'd10668;

   // background thresholds 5/43/84 scaled by 127 * 64, on p * pan weight
   localparam logic [20:0] BG_T1 = 21'd40640;
   localparam logic [20:0] BG_T2 = 21'd349504;
   localparam logic [20:0] BG_T3 = 21'd682752;

   // glyph step bounds (f = p / 127 stepping in elevens, or in ones at low level)
   localparam logic [13:0] LV1_B0 = 14'd762;    // f < 6
   localparam logic [13:0] LV1_B1 = 14'd889;    // f < 7
   localparam logic [13:0] LV1_B2 = 14'd1016;   // f < 8
   localparam logic [13:0] LV2_B0 = 14'd6858;   // f < 54
   localparam logic [13:0] LV2_B1 = 14'd8255;   // f < 65
   localparam logic [13:0] LV2_B2 = 14'd9652;   // f < 76
   localparam logic [13:0] LV3_B0 = 14'd12065;  // f < 95
   localparam logic [13:0] LV3_B1 = 14'd13462;  // f < 106
   localparam logic [13:0] LV3_B2 = 14'd14859;  // f < 117

   // color attributes per level
   localparam logic [7:0] FG_COLOR [4] = '{8'h00, 8'h08, 8'h07, 8'h0F};
   localparam logic [7:0] BG_COLOR [4] = '{8'h00, 8'h80, 8'h70, 8'hF0};

   // request and result payloads
   typedef struct packed {
      logic       mode;
      logic [7:0] status;
      logic [6:0] data1;
      logic [6:0] data2;
      logic [3:0] query_channel;
      logic [6:0] query_pitch;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] glyph;
      logic [7:0] color;
      logic       first_mark;
   } rsp_type;

   // one note cell
   typedef struct packed {
      logic [7:0] glyph;
      logic [7:0] color;
      logic       first;
   } cell_type;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_CALC,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic decode;
      logic calc;
      logic finish;
      logic clear_step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } stat_type;

   // level of intensity from p
   function automatic logic [1:0] fg_level(input logic [13:0] p);
      logic [1:0] lv;
      if (p < FG_T1) lv = 2'd0;
      else if (p < FG_T2) lv = 2'd1;
      else if (p < FG_T3) lv = 2'd2;
      else lv = 2'd3;
      return lv;
   endfunction

   // level of background from pan-weighted product
   function automatic logic [1:0] bg_level(input logic [20:0] q);
      logic [1:0] lv;
      if (q < BG_T1) lv = 2'd0;
      else if (q < BG_T2) lv = 2'd1;
      else if (q < BG_T3) lv = 2'd2;
      else lv = 2'd3;
      return lv;
   endfunction

   // centered pan glyph from p and its intensity level
   function automatic logic [7:0] mid_glyph(input logic [13:0] p, input logic [1:0] lv);
      logic [13:0] b0;
      logic [13:0] b1;
      logic [13:0] b2;
      logic [7:0]  g;
      case (lv)
         2'd1: begin
            b0 = LV1_B0; b1 = LV1_B1; b2 = LV1_B2;
         end
         2'd2: begin
            b0 = LV2_B0; b1 = LV2_B1; b2 = LV2_B2;
         end
         2'd3: begin
            b0 = LV3_B0; b1 = LV3_B1; b2 = LV3_B2;
         end
         default: begin
            b0 = '0; b1 = '0; b2 = '0;
         end
      endcase
      if (lv == 2'd0) g = GLYPH_FULL;
      else if (p < b0) g = GLYPH_DARK;
      else if (p < b1) g = GLYPH_LIGHT;
      else if (p < b2) g = GLYPH_MED;
      else g = GLYPH_FULL;
      return g;
   endfunction

endpackage

[design/mngt_ctrl.sv]
// Controller state machine: clearing pass after reset, then the per-request sequence.
// Depends on mngt_pkg for the state, command and status types.
`timescale 1ns / 1ps

module mngt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  mngt_pkg::stat_type stat,
   output mngt_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);

   mngt_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // state and strobe registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mngt_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = 1'b0;
      case (state_ff)
         mngt_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = mngt_pkg::ST_IDLE;
         end
         mngt_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = mngt_pkg::ST_DECODE;
            end
         end
         mngt_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = mngt_pkg::ST_CALC;
         end
         mngt_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = mngt_pkg::ST_FINISH;
         end
         mngt_pkg::ST_FINISH: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = mngt_pkg::ST_IDLE;
         end
         default: begin
            state_in = mngt_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != mngt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/mngt_dp.sv]
// Datapath: request register, volume/pan registers, note cell memory, two multiply
// stages, glyph/color selection and the result register. Depends on mngt_pkg.
`timescale 1ns / 1ps

module mngt_dp #(
   parameter int CHANNELS = mngt_pkg::CHANNELS_DEF,
   parameter int PITCHES  = mngt_pkg::PITCHES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mngt_pkg::req_type  req_payload,
   input  mngt_pkg::cmd_type  cmd,
   output mngt_pkg::stat_type stat,
   output mngt_pkg::rsp_type  rsp_payload
);

   localparam int DEPTH = CHANNELS * PITCHES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // request register
   mngt_pkg::req_type req_ff;

   // per-channel controller state and note cell memory
   logic [6:0]         vol_ff [CHANNELS];
   logic [6:0]         pan_ff [CHANNELS];
   mngt_pkg::cell_type cells_ff [DEPTH];

   // clearing pass counter
   logic [AW-1:0] clr_ff, clr_in;

   // arithmetic pipeline
   logic [13:0] p_ff, p_in;
   logic [6:0]  m_ff, m_in;
   logic [20:0] q_ff, q_in;
   logic        left_ff, left_in;
   logic        right_ff, right_in;

   // memory read data and result register
   mngt_pkg::cell_type rd_ff;
   mngt_pkg::rsp_type  rsp_ff, rsp_in;

   // decode signals
   logic [3:0]    msg_type;
   logic [3:0]    ch;
   logic [CW-1:0] ch_idx;
   logic          ch_ok;
   logic          pitch_ok;
   logic          query_ok;
   logic [2:0]    act;
   logic [AW-1:0] note_addr;
   logic [AW-1:0] query_addr;
   logic [6:0]    vol_rd;
   logic [6:0]    pan_rd;

   // draw signals
   logic [1:0]         fg_lv;
   logic [1:0]         bg_lv;
   logic [7:0]         draw_glyph;
   mngt_pkg::cell_type draw_cell;

   // memory write port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   mngt_pkg::cell_type wr_data;

   // message decode
   always_comb begin
      msg_type   = req_ff.status[7:4];
      ch         = req_ff.status[3:0];
      ch_idx     = ch[CW-1:0];
      ch_ok      = ({1'b0, ch} < 5'(CHANNELS));
      pitch_ok   = ({1'b0, req_ff.data1} < 8'(PITCHES));
      query_ok   = ({1'b0, req_ff.query_channel} < 5'(CHANNELS))
                   && ({1'b0, req_ff.query_pitch} < 8'(PITCHES));
      note_addr  = AW'(32'(ch) * 32'(PITCHES) + 32'(req_ff.data1));
      query_addr = AW'(32'(req_ff.query_channel) * 32'(PITCHES) + 32'(req_ff.query_pitch));
      vol_rd     = vol_ff[ch_idx];
      pan_rd     = pan_ff[ch_idx];

      if (req_ff.mode) begin
         act = mngt_pkg::ACT_READ;
      end else if (!ch_ok) begin
         act = mngt_pkg::ACT_IGNORE;
      end else if (msg_type == mngt_pkg::TYPE_CONTROL && req_ff.data1 == mngt_pkg::CC_VOLUME) begin
         act = mngt_pkg::ACT_VOLUME;
      end else if (msg_type == mngt_pkg::TYPE_CONTROL && req_ff.data1 == mngt_pkg::CC_PAN) begin
         act = mngt_pkg::ACT_PAN;
      end else if (msg_type == mngt_pkg::TYPE_NOTE_OFF || msg_type == mngt_pkg::TYPE_NOTE_ON) begin
         if (!pitch_ok) act = mngt_pkg::ACT_IGNORE;
         else if (msg_type == mngt_pkg::TYPE_NOTE_OFF || req_ff.data2 == 7'd0)
            act = mngt_pkg::ACT_CLEAR;
         else act = mngt_pkg::ACT_DRAW;
      end else begin
         act = mngt_pkg::ACT_IGNORE;
      end
   end

   // first stage: intensity product and pan weight
   always_comb begin
      p_in     = p_ff;
      m_in     = m_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (cmd.decode) begin
         p_in     = 14'(req_ff.data2 * vol_rd);
         left_in  = (pan_rd < mngt_pkg::PAN_LEFT_LIM);
         right_in = (pan_rd > mngt_pkg::PAN_RIGHT_LIM);
         m_in     = (pan_rd < mngt_pkg::PAN_LEFT_LIM) ? pan_rd : (mngt_pkg::PAN_MAX - pan_rd);
      end
   end

   // second stage: pan-weighted background product
   assign q_in = cmd.calc ? 21'(p_ff * m_ff) : q_ff;

   // glyph and color of a drawn note
   always_comb begin
      fg_lv = mngt_pkg::fg_level(p_ff);
      if (left_ff) begin
         draw_glyph = mngt_pkg::GLYPH_LEFT;
         bg_lv      = mngt_pkg::bg_level(q_ff);
      end else if (right_ff) begin
         draw_glyph = mngt_pkg::GLYPH_RIGHT;
         bg_lv      = mngt_pkg::bg_level(q_ff);
      end else begin
         draw_glyph = mngt_pkg::mid_glyph(p_ff, fg_lv);
         case (fg_lv)
            2'd3:    bg_lv = 2'd2;
            2'd2:    bg_lv = 2'd1;
            default: bg_lv = 2'd0;
         endcase
      end
      draw_cell.glyph = draw_glyph;
      draw_cell.color = mngt_pkg::FG_COLOR[fg_lv] | mngt_pkg::BG_COLOR[bg_lv];
      draw_cell.first = 1'b1;
   end

   // result selection
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in        = '0;
         rsp_in.action = act;
         if (act == mngt_pkg::ACT_DRAW) begin
            rsp_in.glyph      = draw_cell.glyph;
            rsp_in.color      = draw_cell.color;
            rsp_in.first_mark = draw_cell.first;
         end else if (act == mngt_pkg::ACT_READ && query_ok) begin
            rsp_in.glyph      = rd_ff.glyph;
            rsp_in.color      = rd_ff.color;
            rsp_in.first_mark = rd_ff.first;
         end
      end
   end

   // memory write port: clearing pass or note update
   always_comb begin
      clr_in  = cmd.clear_step ? clr_ff + 1'b1 : clr_ff;
      wr_en   = 1'b0;
      wr_addr = note_addr;
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (cmd.finish && act == mngt_pkg::ACT_CLEAR) begin
         wr_en = 1'b1;
      end else if (cmd.finish && act == mngt_pkg::ACT_DRAW) begin
         wr_en   = 1'b1;
         wr_data = draw_cell;
      end
   end

   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // volume and pan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            vol_ff[i] <= mngt_pkg::CC_RESET;
            pan_ff[i] <= mngt_pkg::CC_RESET;
         end
      end else if (cmd.finish) begin
         if (act == mngt_pkg::ACT_VOLUME) vol_ff[ch_idx] <= req_ff.data2;
         if (act == mngt_pkg::ACT_PAN) pan_ff[ch_idx] <= req_ff.data2;
      end
   end

   // note cell memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) cells_ff[wr_addr] <= wr_data;
      if (cmd.decode && query_ok) rd_ff <= cells_ff[query_addr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_payload;
      p_ff     <= p_in;
      m_ff     <= m_in;
      q_ff     <= q_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

[design/midi_note_glyph_tracker_unit.sv]
// Top level of the MIDI note glyph tracker: joins controller and datapath.
// Depends on mngt_pkg, mngt_ctrl and mngt_dp.
//
//   channel   ports                     handshake
//   request   start, busy, req_payload  taken when start is high and busy is low
//   result    rsp_valid, rsp_payload    one-cycle strobe, always taken
//
// After acceptance a request passes through decode with the velocity*volume multiply
// and the cell memory read, the pan-weight multiply, then selection and the memory
// write, ahead of its result strobe. busy stays low in the cycle the result shows,
// so the next request can enter then; a new request is not taken while one is in flight.
// After reset the cell memory is cleared one entry a cycle, all CHANNELS*PITCHES
// entries (2048 by default), with busy high. The result side never stalls.
`timescale 1ns / 1ps

module midi_note_glyph_tracker_unit #(
   parameter int CHANNELS = mngt_pkg::CHANNELS_DEF,
   parameter int PITCHES  = mngt_pkg::PITCHES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mngt_pkg::req_type req_payload,
   output logic              rsp_valid,
   output mngt_pkg::rsp_type rsp_payload
);

   mngt_pkg::cmd_type  cmd;
   mngt_pkg::stat_type stat;

   // sequencing
   mngt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // storage and arithmetic
   mngt_dp #(
      .CHANNELS (CHANNELS),
      .PITCHES  (PITCHES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

[design/mngt_checker.sv]
// Port-level checks for the MIDI note glyph tracker, bound to the top level.
// Depends on mngt_pkg and midi_note_glyph_tracker_unit.
`timescale 1ns / 1ps

module mngt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input mngt_pkg::rsp_type rsp_payload
);

   // every accepted request answers with a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("result strobe missing four cycles after request");

   // a taken request makes the block busy, through the state register
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // results other than draw and read carry empty fields
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.action == mngt_pkg::ACT_IGNORE
                     || rsp_payload.action == mngt_pkg::ACT_VOLUME
                     || rsp_payload.action == mngt_pkg::ACT_PAN
                     || rsp_payload.action == mngt_pkg::ACT_CLEAR))
      |-> (rsp_payload.glyph == 8'd0 && rsp_payload.color == 8'd0
           && !rsp_payload.first_mark))
      else $error("non-empty fields on a cell-less result");

   // a drawn note always comes back marked first
   a_draw_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.action == mngt_pkg::ACT_DRAW) |-> rsp_payload.first_mark)
      else $error("drawn note without first mark");

endmodule

bind midi_note_glyph_tracker_unit mngt_checker u_mngt_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

[bench/tb_midi_note_glyph_tracker_unit.sv]
// Self-checking testbench for midi_note_glyph_tracker_unit: directed and random requests,
// predicted results checked in order. Depends on mngt_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tb_midi_note_glyph_tracker_unit;

   // message codes that the block ignores
   localparam logic [3:0] TYPE_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] TYPE_SYSTEM        = 4'hF;
   localparam logic [6:0] CC_EXPRESSION      = 7'd11;

   // requests per random phase and the number of phases
   localparam int PHASE_REQUESTS = 400;
   localparam int PHASES         = 4;

   // scoreboard: mirrors volume, pan and the note cells, holds results still due
   class note_glyph_board;
      localparam int BAND_DIM   = 5;
      localparam int BAND_MID   = 43;
      localparam int BAND_HIGH  = 84;
      localparam int GLYPH_STEP = 11;

      logic [6:0]         chan_volume [16];
      logic [6:0]         chan_pan [16];
      mngt_pkg::cell_type cells [16][128];
      mngt_pkg::rsp_type  due_results [$];
      int                 mismatch_count;

      function new();
         foreach (chan_volume[i]) begin
            chan_volume[i] = mngt_pkg::CC_RESET;
            chan_pan[i]    = mngt_pkg::CC_RESET;
         end
         foreach (cells[i, j]) cells[i][j] = '0;
         mismatch_count = 0;
      endfunction

      // band 0..3 of num/den against 5, 43 and 84, exact
      function int intensity_band(int num, int den);
         if (num < BAND_DIM * den) return 0;
         if (num < BAND_MID * den) return 1;
         if (num < BAND_HIGH * den) return 2;
         return 3;
      endfunction

      // color nibble of a band
      function logic [3:0] band_tint(int band);
         case (band)
            1: return 4'h8;
            2: return 4'h7;
            3: return 4'hF;
            default: return 4'h0;
         endcase
      endfunction

      // glyph and color of a freshly struck note
      function mngt_pkg::cell_type shade_note(int vel, int vol, int pan);
         mngt_pkg::cell_type c;
         int p;
         int f;
         int k;
         int fore;
         int back;
         p = vel * vol;
         fore = intensity_band(p, 127);
         if (pan < mngt_pkg::PAN_LEFT_LIM) begin
            c.glyph = mngt_pkg::GLYPH_LEFT;
            back = intensity_band(p * pan, 127 * 64);
         end else if (pan > mngt_pkg::PAN_RIGHT_LIM) begin
            c.glyph = mngt_pkg::GLYPH_RIGHT;
            back = intensity_band(p * (127 - pan), 127 * 64);
         end else begin
            f = p / 127;
            case (fore)
               3: begin
                  back = 2;
                  k = (f - BAND_HIGH) / GLYPH_STEP;
               end
               2: begin
                  back = 1;
                  k = (f - BAND_MID) / GLYPH_STEP;
               end
               1: begin
                  back = 0;
                  k = f - BAND_DIM;
               end
               default: begin
                  back = 0;
                  k = 3;
               end
            endcase
            case (k)
               0: c.glyph = mngt_pkg::GLYPH_DARK;
               1: c.glyph = mngt_pkg::GLYPH_LIGHT;
               2: c.glyph = mngt_pkg::GLYPH_MED;
               default: c.glyph = mngt_pkg::GLYPH_FULL;
            endcase
         end
         c.color = {band_tint(back), band_tint(fore)};
         c.first = 1'b1;
         return c;
      endfunction

      // apply an accepted request to the mirror and queue its result
      function void note_request(mngt_pkg::req_type r);
         mngt_pkg::rsp_type  res;
         mngt_pkg::cell_type c;
         logic [3:0]         kind;
         logic [3:0]         ch;
         res  = '0;
         kind = r.status[7:4];
         ch   = r.status[3:0];
         if (r.mode) begin
            c = cells[r.query_channel][r.query_pitch];
            res.action     = mngt_pkg::ACT_READ;
            res.glyph      = c.glyph;
            res.color      = c.color;
            res.first_mark = c.first;
         end else if (kind == mngt_pkg::TYPE_CONTROL && r.data1 == mngt_pkg::CC_VOLUME) begin
            chan_volume[ch] = r.data2;
            res.action = mngt_pkg::ACT_VOLUME;
         end else if (kind == mngt_pkg::TYPE_CONTROL && r.data1 == mngt_pkg::CC_PAN) begin
            chan_pan[ch] = r.data2;
            res.action = mngt_pkg::ACT_PAN;
         end else if (kind == mngt_pkg::TYPE_NOTE_OFF || kind == mngt_pkg::TYPE_NOTE_ON) begin
            if (kind == mngt_pkg::TYPE_NOTE_OFF || r.data2 == 7'd0) begin
               cells[ch][r.data1] = '0;
               res.action = mngt_pkg::ACT_CLEAR;
            end else begin
               c = shade_note(r.data2, chan_volume[ch], chan_pan[ch]);
               cells[ch][r.data1] = c;
               res.action     = mngt_pkg::ACT_DRAW;
               res.glyph      = c.glyph;
               res.color      = c.color;
               res.first_mark = c.first;
            end
         end else begin
            res.action = mngt_pkg::ACT_IGNORE;
         end
         due_results = {due_results, res};
      endfunction

      // compare one result strobe with the oldest one due
      function void check_response(mngt_pkg::rsp_type got);
         mngt_pkg::rsp_type want;
         if (due_results.size() == 0) begin
            $error("result with none due: action %0d glyph %h color %h first_mark %0d",
                   got.action, got.glyph, got.color, got.first_mark);
            mismatch_count++;
            return;
         end
         want = due_results.pop_front();
         if (got.action !== want.action) begin
            $error("action expected %0d actual %0d", want.action, got.action);
            mismatch_count++;
         end
         if (got.glyph !== want.glyph) begin
            $error("glyph expected %h actual %h", want.glyph, got.glyph);
            mismatch_count++;
         end
         if (got.color !== want.color) begin
            $error("color expected %h actual %h", want.color, got.color);
            mismatch_count++;
         end
         if (got.first_mark !== want.first_mark) begin
            $error("first_mark expected %0d actual %0d", want.first_mark, got.first_mark);
            mismatch_count++;
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // results that never arrived
      function void flag_leftovers();
         foreach (due_results[i]) begin
            $error("result never arrived: action %0d", due_results[i].action);
            mismatch_count++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   mngt_pkg::req_type req_payload;
   logic              rsp_valid;
   mngt_pkg::rsp_type rsp_payload;

   note_glyph_board board;
   int              idle_odds [PHASES] = '{0, 62, 0, 21};

   midi_note_glyph_tracker_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result check first, then the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_response(rsp_payload);
         if (start && !busy) board.note_request(req_payload);
      end
   end

   function automatic mngt_pkg::req_type midi_msg(logic [7:0] status, logic [6:0] d1,
                                                  logic [6:0] d2);
      mngt_pkg::req_type r;
      r        = '0;
      r.status = status;
      r.data1  = d1;
      r.data2  = d2;
      return r;
   endfunction

   function automatic mngt_pkg::req_type cell_query(logic [3:0] qc, logic [6:0] qp);
      mngt_pkg::req_type r;
      r               = '0;
      r.mode          = 1'b1;
      r.query_channel = qc;
      r.query_pitch   = qp;
      return r;
   endfunction

   // mostly a few channels and pitches so reads land on drawn cells
   function automatic logic [3:0] pick_channel();
      return ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
   endfunction

   function automatic logic [6:0] pick_pitch();
      return ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 7)) : 7'($urandom);
   endfunction

   // well-formed messages with random content, some noise
   function automatic mngt_pkg::req_type random_request();
      mngt_pkg::req_type r;
      int                roll;
      int                sel;
      r.mode          = 1'b0;
      r.status        = 8'($urandom);
      r.data1         = 7'($urandom);
      r.data2         = 7'($urandom);
      r.query_channel = 4'($urandom);
      r.query_pitch   = 7'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         r.mode = 1'($urandom);
      end else if (roll < 27) begin
         r.status = {mngt_pkg::TYPE_CONTROL, pick_channel()};
         sel = $urandom_range(0, 9);
         if (sel < 5) r.data1 = mngt_pkg::CC_VOLUME;
         else if (sel < 9) r.data1 = mngt_pkg::CC_PAN;
         if ($urandom_range(0, 4) == 0) r.data2 = ($urandom_range(0, 1) != 0) ? 7'd127 : 7'd0;
      end else if (roll < 57) begin
         r.status = {mngt_pkg::TYPE_NOTE_ON, pick_channel()};
         r.data1  = pick_pitch();
         r.data2  = ($urandom_range(0, 11) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
      end else if (roll < 67) begin
         r.status = {mngt_pkg::TYPE_NOTE_OFF, pick_channel()};
         r.data1  = pick_pitch();
      end else begin
         r.mode          = 1'b1;
         r.query_channel = pick_channel();
         r.query_pitch   = pick_pitch();
      end
      return r;
   endfunction

   // hold start until the request is taken
   task automatic push_request(mngt_pkg::req_type r);
      @(negedge clock);
      start       = 1'b1;
      req_payload = r;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start       = 1'b0;
         req_payload = random_request();
      end
   endtask

   // extremes, every result action and the pan and intensity limits
   task automatic run_directed();
      push_request(cell_query(4'd0, 7'd0));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd0}, 7'd60, 7'd100));
      push_request(cell_query(4'd0, 7'd60));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd0}, 7'd60, 7'd0));
      push_request(cell_query(4'd0, 7'd60));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd1}, mngt_pkg::CC_VOLUME, 7'd127));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd1}, mngt_pkg::CC_PAN, 7'd0));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd1}, 7'd127, 7'd127));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd1}, mngt_pkg::CC_PAN, 7'd127));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd1}, 7'd0, 7'd127));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd1}, mngt_pkg::CC_PAN, 7'd51));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd1}, 7'd1, 7'd127));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd1}, mngt_pkg::CC_PAN, 7'd52));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd1}, 7'd2, 7'd127));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd1}, mngt_pkg::CC_PAN, 7'd76));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd1}, 7'd3, 7'd84));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd1}, 7'd5, 7'd5));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd1}, mngt_pkg::CC_PAN, 7'd77));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd1}, 7'd4, 7'd4));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_OFF, 4'd1}, 7'd127, 7'd127));
      push_request(cell_query(4'd15, 7'd127));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd2}, mngt_pkg::CC_VOLUME, 7'd0));
      push_request(midi_msg({mngt_pkg::TYPE_NOTE_ON, 4'd2}, 7'd10, 7'd127));
      push_request(midi_msg({TYPE_POLY_PRESSURE, 4'd5}, 7'd60, 7'd64));
      push_request(midi_msg({mngt_pkg::TYPE_CONTROL, 4'd3}, CC_EXPRESSION, 7'd127));
      push_request(midi_msg({TYPE_SYSTEM, 4'd15}, 7'd127, 7'd127));
   endtask

   // stimulus and end of run
   initial begin
      int waited;
      start       = 1'b0;
      req_payload = '0;
      reset       = 1'b1;
      board       = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      for (int ph = 0; ph < PHASES; ph++) begin
         repeat (PHASE_REQUESTS) begin
            push_request(random_request());
            if ($urandom_range(0, 99) < idle_odds[ph]) idle_sender($urandom_range(1, 6));
         end
      end
      idle_sender(1);

      // drain outstanding results
      waited = 0;
      while (board.pending() != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      board.flag_leftovers();
      if (board.mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
